[rtl/bip39_pkg.sv]
// ----------------------------------------------------------------------------
// bip39_pkg
// Shared types and constants for the mnemonic index encoder.
// ----------------------------------------------------------------------------
package bip39_pkg;

   localparam int unsigned IDX_BITS   = 11;
   localparam int unsigned WORD_COUNT = 24;
   localparam int unsigned BYTE_COUNT = 32;
   localparam int unsigned BYTE_TOP   = 7;
   localparam int unsigned ROUNDS     = 64;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       store_byte;
      logic       init_hash;
      logic       do_round;
      logic       finish_hash;
      logic       shift_word;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       last_byte;
      logic       last_round;
      logic       last_word;
   } status_type;

   typedef logic [31:0] word_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sha_k(input logic [5:0] t);
      word_type k;
      unique case (t)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      sha_k = k;
   endfunction

   localparam word_type IV_A = 32'h6a09e667;
   localparam word_type IV_B = 32'hbb67ae85;
   localparam word_type IV_C = 32'h3c6ef372;
   localparam word_type IV_D = 32'ha54ff53a;
   localparam word_type IV_E = 32'h510e527f;
   localparam word_type IV_F = 32'h9b05688c;
   localparam word_type IV_G = 32'h1f83d9ab;
   localparam word_type IV_H = 32'h5be0cd19;

endpackage

[rtl/bip39_mnemonic_index_encoder.sv]
// Sequence: after the 32nd byte is accepted, the init, round and finish states
//   run in turn, then 24 indexes are emitted on consecutive cycles.
// Throughput: one byte per cycle while loading; no new entropy is taken until
//   the single-round SHA-256 core and the index emission are done.
// Reset clears the byte, round and word counters and the sequencer.
// The receiver cannot stall; busy is high from the 32nd byte to the last index.
// ----------------------------------------------------------------------------
// bip39_mnemonic_index_encoder
// 256-bit entropy to 24 mnemonic word indexes with SHA-256 checksum.
// ----------------------------------------------------------------------------
module bip39_mnemonic_index_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_entropy_byte,
   output logic        rsp_strobe,
   output logic [10:0] rsp_word_index,
   output logic        rsp_last_word
);

   bip39_pkg::cmd_type    cmd;
   bip39_pkg::status_type status;

   bip39_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .emit   (rsp_strobe)
   );

   bip39_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .entropy_byte (req_entropy_byte),
      .status       (status),
      .word_index   (rsp_word_index),
      .last_word    (rsp_last_word)
   );

endmodule

[rtl/bip39_ctrl.sv]
// ----------------------------------------------------------------------------
// bip39_ctrl
// Sequencer: byte load, hash init, hash rounds, digest finish, index emission.
// ----------------------------------------------------------------------------
module bip39_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  bip39_pkg::status_type status,
   output bip39_pkg::cmd_type    cmd,
   output logic                  busy,
   output logic                  emit
);

   bip39_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bip39_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bip39_pkg::ST_LOAD: begin
            if (start && status.last_byte) state_in = bip39_pkg::ST_INIT;
         end
         bip39_pkg::ST_INIT:  state_in = bip39_pkg::ST_ROUND;
         bip39_pkg::ST_ROUND: begin
            if (status.last_round) state_in = bip39_pkg::ST_FINAL;
         end
         bip39_pkg::ST_FINAL: state_in = bip39_pkg::ST_EMIT;
         bip39_pkg::ST_EMIT: begin
            if (status.last_word) state_in = bip39_pkg::ST_LOAD;
         end
         default: state_in = bip39_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      emit = 1'b0;
      unique case (state_ff)
         bip39_pkg::ST_LOAD: begin
            busy           = 1'b0;
            cmd.store_byte = start;
         end
         bip39_pkg::ST_INIT:  cmd.init_hash   = 1'b1;
         bip39_pkg::ST_ROUND: cmd.do_round    = 1'b1;
         bip39_pkg::ST_FINAL: cmd.finish_hash = 1'b1;
         bip39_pkg::ST_EMIT: begin
            cmd.shift_word = 1'b1;
            emit           = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

[rtl/bip39_datapath.sv]
// ----------------------------------------------------------------------------
// bip39_datapath
// Entropy shift register, one-round SHA-256 core and index shifter.
// ----------------------------------------------------------------------------
module bip39_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  bip39_pkg::cmd_type    cmd,
   input  logic [7:0]            entropy_byte,
   output bip39_pkg::status_type status,
   output logic [10:0]           word_index,
   output logic                  last_word
);

   typedef bip39_pkg::word_type word_type;

   logic [255:0] ent_ff, ent_in;
   logic [263:0] out_ff, out_in;
   logic [4:0]   bytes_ff, bytes_in;
   logic [5:0]   round_ff, round_in;
   logic [4:0]   words_ff, words_in;
   word_type     sched_ff [16];
   word_type     sched_in [16];
   word_type     a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   word_type     a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in;
   word_type     w_new, s0w, s1w, t1, t2, w_cur;
   word_type     digest0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= '0;
         round_ff <= '0;
         words_ff <= '0;
      end else begin
         bytes_ff <= bytes_in;
         round_ff <= round_in;
         words_ff <= words_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      out_ff <= out_in;
      sched_ff <= sched_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      e_ff <= e_in; f_ff <= f_in; g_ff <= g_in; h_ff <= h_in;
   end

   // schedule word and round terms for the current round; window slides by one each round
   always_comb begin
      s0w   = bip39_pkg::rotr(sched_ff[1], 7) ^ bip39_pkg::rotr(sched_ff[1], 18)
            ^ (sched_ff[1] >> 3);
      s1w   = bip39_pkg::rotr(sched_ff[14], 17) ^ bip39_pkg::rotr(sched_ff[14], 19)
            ^ (sched_ff[14] >> 10);
      w_new = sched_ff[0] + s0w + s1w + sched_ff[9];
      w_cur = sched_ff[0];
      t1 = h_ff + (bip39_pkg::rotr(e_ff, 6) ^ bip39_pkg::rotr(e_ff, 11)
           ^ bip39_pkg::rotr(e_ff, 25)) + ((e_ff & f_ff) ^ (~e_ff & g_ff))
           + bip39_pkg::sha_k(round_ff) + w_cur;
      t2 = (bip39_pkg::rotr(a_ff, 2) ^ bip39_pkg::rotr(a_ff, 13)
           ^ bip39_pkg::rotr(a_ff, 22)) + ((a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff));
      digest0 = a_ff + bip39_pkg::IV_A;
   end

   always_comb begin
      ent_in   = ent_ff;
      out_in   = out_ff;
      bytes_in = bytes_ff;
      round_in = round_ff;
      words_in = words_ff;
      sched_in = sched_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      e_in = e_ff; f_in = f_ff; g_in = g_ff; h_in = h_ff;
      if (cmd.store_byte) begin
         ent_in   = {ent_ff[247:0], entropy_byte};
         bytes_in = bytes_ff + 5'd1;
      end
      if (cmd.init_hash) begin
         for (int i = 0; i < 8; i++) begin
            sched_in[i] = ent_ff[255 - 32*i -: 32];
         end
         sched_in[8] = 32'h80000000;
         for (int i = 9; i < 15; i++) begin
            sched_in[i] = '0;
         end
         sched_in[15] = 32'd256;
         a_in = bip39_pkg::IV_A; b_in = bip39_pkg::IV_B;
         c_in = bip39_pkg::IV_C; d_in = bip39_pkg::IV_D;
         e_in = bip39_pkg::IV_E; f_in = bip39_pkg::IV_F;
         g_in = bip39_pkg::IV_G; h_in = bip39_pkg::IV_H;
         round_in = '0;
      end
      if (cmd.do_round) begin
         for (int i = 0; i < 15; i++) begin
            sched_in[i] = sched_ff[i + 1];
         end
         sched_in[15] = w_new;
         h_in = g_ff; g_in = f_ff; f_in = e_ff; e_in = d_ff + t1;
         d_in = c_ff; c_in = b_ff; b_in = a_ff; a_in = t1 + t2;
         round_in = round_ff + 6'd1;
      end
      if (cmd.finish_hash) begin
         out_in   = {ent_ff, digest0[31:24]};
         words_in = '0;
      end
      if (cmd.shift_word) begin
         out_in   = {out_ff[252:0], 11'd0};
         words_in = (words_ff == 5'(bip39_pkg::WORD_COUNT - 1)) ? 5'd0 : words_ff + 5'd1;
      end
   end

   assign word_index        = out_ff[263:253];
   assign last_word         = (words_ff == 5'(bip39_pkg::WORD_COUNT - 1));
   assign status.last_byte  = (bytes_ff == 5'(bip39_pkg::BYTE_COUNT - 1));
   assign status.last_round = (round_ff == 6'(bip39_pkg::ROUNDS - 1));
   assign status.last_word  = last_word;

endmodule

[rtl/bip39_checker.sv]
// ----------------------------------------------------------------------------
// bip39_checker
// Port-level checks of the encoder's transaction sequencing.
// ----------------------------------------------------------------------------
module bip39_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_last_word
);

   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> busy)
      else $error("result while idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_word |=> !busy)
      else $error("busy after last index");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_word |=> rsp_strobe)
      else $error("gap in index burst");

   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_strobe) |-> $past(rsp_last_word))
      else $error("burst ended early");

endmodule

bind bip39_mnemonic_index_encoder bip39_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_last_word (rsp_last_word)
);
